// ===== rtl/atatf_pkg.sv =====
// ----------------------------------------------------------------------------
// atatf_pkg
// Shared types and constants for the ATA task-file command generator.
// ----------------------------------------------------------------------------
package atatf_pkg;

    // Sizing defaults
    localparam int MAX_CHUNKS_DEF  = 64;
    localparam int RESULT_LIMIT    = 64;
    localparam int FIFO_DEPTH_DEF  = 4;

    // Geometry and splitting constants
    localparam logic [8:0]  CHUNK_MAX          = 9'd256;
    localparam logic [6:0]  SECT_PER_TRACK     = 7'd63;
    // Inverse of 63 modulo 2^32, for exact division of multiples of 63
    localparam logic [31:0] SECT_PER_TRACK_INV = 32'hBEFB_EFBF;

    // Configuration register indexes
    localparam logic REG_LBA_SUPPORTED = 1'b0;
    localparam logic REG_DRIVE_NUMBER  = 1'b1;

    // Addressing modes
    localparam logic [1:0] MODE_CHS   = 2'd0;
    localparam logic [1:0] MODE_LBA28 = 2'd1;
    localparam logic [1:0] MODE_LBA48 = 2'd2;

    // Task-file constants
    localparam logic [7:0] DEV_BASE      = 8'hE0;
    localparam logic [7:0] CMD_READ      = 8'h20;
    localparam logic [7:0] CMD_READ_EXT  = 8'h24;
    localparam logic [7:0] CMD_WRITE     = 8'h30;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

    // One chunk handed from the splitter to the builder
    typedef struct packed {
        logic        func;
        logic [31:0] addr;
        logic [8:0]  size;
        logic        last;
    } t_chunk;

    // Live configuration
    typedef struct packed {
        logic lba_supported;
        logic drive_number;
    } t_cfg;

    // One task-file setup
    typedef struct packed {
        logic [1:0] addressing_mode;
        logic [7:0] device_byte;
        logic [7:0] sector_count_reg;
        logic [7:0] lba_low;
        logic [7:0] lba_mid;
        logic [7:0] lba_high;
        logic [7:0] lba_ext_low;
        logic [7:0] command_byte;
        logic [8:0] chunk_sectors;
        logic       last;
    } t_result;

endpackage

// ===== rtl/atatf_front.sv =====
// ----------------------------------------------------------------------------
// atatf_front
// Request splitter: takes a transfer request and pushes one chunk
// descriptor (at most 256 sectors) per cycle into the chunk queue while it is not full.
// ----------------------------------------------------------------------------
module atatf_front #(
    parameter int MAX_CHUNKS = atatf_pkg::MAX_CHUNKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [31:0]        i_start_lba,
    input  logic [14:0]        i_sector_count,
    input  logic               i_q_full,
    output logic               o_q_push,
    output atatf_pkg::t_chunk  o_q_data
);

    localparam int LIMIT = (MAX_CHUNKS < atatf_pkg::RESULT_LIMIT) ?
                           MAX_CHUNKS : atatf_pkg::RESULT_LIMIT;
    localparam int CW    = (LIMIT > 1) ? $clog2(LIMIT) : 1;

    logic          r_busy, n_busy;
    logic          r_func, n_func;
    logic [31:0]   r_addr, n_addr;
    logic [14:0]   r_rem,  n_rem;
    logic [CW-1:0] r_n,    n_n;

    logic          accept;
    logic [8:0]    size;
    logic          last;

    assign o_ready = !r_busy;
    assign accept  = i_valid && !r_busy;

    // Current chunk size and last mark
    always_comb begin
        if (r_rem > 15'(atatf_pkg::CHUNK_MAX)) begin
            size = atatf_pkg::CHUNK_MAX;
        end else begin
            size = r_rem[8:0];
        end
        last = (r_rem <= 15'(atatf_pkg::CHUNK_MAX)) || (r_n == CW'(LIMIT - 1));
    end

    assign o_q_push = r_busy && !i_q_full;
    assign o_q_data = '{func: r_func, addr: r_addr, size: size, last: last};

    // Splitter state
    always_comb begin
        n_busy = r_busy;
        n_func = r_func;
        n_addr = r_addr;
        n_rem  = r_rem;
        n_n    = r_n;
        if (accept) begin
            n_busy = (i_sector_count != 15'd0);
            n_func = i_func;
            n_addr = i_start_lba;
            n_rem  = i_sector_count;
            n_n    = '0;
        end else if (o_q_push) begin
            n_addr = r_addr + 32'(size);
            n_rem  = r_rem - 15'(size);
            n_n    = r_n + CW'(1);
            if (last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_func <= n_func;
        r_addr <= n_addr;
        r_rem  <= n_rem;
        r_n    <= n_n;
    end

endmodule

// ===== rtl/atatf_queue.sv =====
// ----------------------------------------------------------------------------
// atatf_queue
// Small FIFO of chunk descriptors between splitter and builder.
// ----------------------------------------------------------------------------
module atatf_queue #(
    parameter int DEPTH = atatf_pkg::FIFO_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  atatf_pkg::t_chunk  i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output atatf_pkg::t_chunk  o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    atatf_pkg::t_chunk r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/atatf_back.sv =====
// ----------------------------------------------------------------------------
// atatf_back
// Task-file builder: pops a chunk, picks the addressing mode, splits the
// address by 63 for CHS in two steps, and loads the output register.
// ----------------------------------------------------------------------------
module atatf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  atatf_pkg::t_cfg    i_cfg,
    input  logic               i_q_empty,
    input  atatf_pkg::t_chunk  i_q_data,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output atatf_pkg::t_result o_result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]         r_state, n_state;
    atatf_pkg::t_chunk  r_desc;
    logic [31:0]        r_quo;
    logic [5:0]         r_rem;
    logic               r_valid;
    atatf_pkg::t_result r_result;

    logic [8:0]         digit_sum;
    logic [6:0]         digit_fold;
    logic [5:0]         mod63;
    logic [31:0]        quo_exact;
    logic               load;
    logic [1:0]         mode;
    logic [3:0]         head;
    logic [7:0]         b0, b1, b2, b3;
    atatf_pkg::t_result result;

    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;
    assign load     = (r_state == S_EMIT) && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Remainder by 63: 64 is 1 mod 63, so sum the 6-bit digits and fold
    assign digit_sum  = 9'(r_desc.addr[5:0])   + 9'(r_desc.addr[11:6])  +
                        9'(r_desc.addr[17:12]) + 9'(r_desc.addr[23:18]) +
                        9'(r_desc.addr[29:24]) + 9'(r_desc.addr[31:30]);
    assign digit_fold = 7'(digit_sum[5:0]) + 7'(digit_sum[8:6]);
    assign mod63      = (digit_fold >= atatf_pkg::SECT_PER_TRACK) ?
                        6'(digit_fold - atatf_pkg::SECT_PER_TRACK) : digit_fold[5:0];

    // Quotient by 63: address minus remainder is an exact multiple
    assign quo_exact = (r_desc.addr - {26'd0, r_rem}) * atatf_pkg::SECT_PER_TRACK_INV;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_cfg.lba_supported ? S_EMIT : S_MOD;
                end
            end
            S_MOD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Descriptor latch and divider datapath
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_desc <= i_q_data;
        end
        if (r_state == S_MOD) begin
            r_rem <= mod63;
        end
        if (r_state == S_DIV) begin
            r_quo <= quo_exact;
        end
    end

    // Field build: quotient is the track, remainder the sector offset
    always_comb begin
        if (!i_cfg.lba_supported) begin
            mode = atatf_pkg::MODE_CHS;
            b0   = 8'(r_rem) + 8'd1;
            b1   = r_quo[11:4];
            b2   = r_quo[19:12];
            b3   = 8'd0;
            head = r_quo[3:0];
        end else if (r_desc.addr[31:28] != 4'd0) begin
            mode = atatf_pkg::MODE_LBA48;
            b0   = r_desc.addr[7:0];
            b1   = r_desc.addr[15:8];
            b2   = r_desc.addr[23:16];
            b3   = r_desc.addr[31:24];
            head = 4'd0;
        end else begin
            mode = atatf_pkg::MODE_LBA28;
            b0   = r_desc.addr[7:0];
            b1   = r_desc.addr[15:8];
            b2   = r_desc.addr[23:16];
            b3   = 8'd0;
            head = r_desc.addr[27:24];
        end

        result.addressing_mode  = mode;
        result.device_byte      = atatf_pkg::DEV_BASE | {3'd0, i_cfg.drive_number, head};
        result.sector_count_reg = r_desc.size[7:0];
        result.lba_low          = b0;
        result.lba_mid          = b1;
        result.lba_high         = b2;
        result.lba_ext_low      = b3;
        if (r_desc.func) begin
            result.command_byte = (mode == atatf_pkg::MODE_LBA48) ?
                                  atatf_pkg::CMD_WRITE_EXT : atatf_pkg::CMD_WRITE;
        end else begin
            result.command_byte = (mode == atatf_pkg::MODE_LBA48) ?
                                  atatf_pkg::CMD_READ_EXT : atatf_pkg::CMD_READ;
        end
        result.chunk_sectors    = r_desc.size;
        result.last             = r_desc.last;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= result;
        end
    end

endmodule

// ===== rtl/ata_taskfile_command_generator_unit.sv =====
// LBA chunks pass the splitter, the chunk queue and the builder's idle and
// emit states; CHS chunks also pass its remainder and quotient states by 63.
// The builder pops the next chunk only after loading the last one into the output;
// the next request is taken the cycle after the splitter queues the last chunk.
// Reset (synchronous, active low) empties the queue and output register and
// sets lba_supported to 1 and drive_number to 0.
// ----------------------------------------------------------------------------
// ata_taskfile_command_generator_unit
// Splits transfer requests into chunks and emits one ATA task-file setup
// per chunk: splitter, chunk queue, builder.
// ----------------------------------------------------------------------------
module ata_taskfile_command_generator_unit #(
    parameter int MAX_CHUNKS = atatf_pkg::MAX_CHUNKS_DEF,
    parameter int FIFO_DEPTH = atatf_pkg::FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic        i_cfg_wdata,
    // Request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // start_lba[31:0], sector_count[46:32]
    input  logic        i_s_axis_tuser,  // func
    // Task-file stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,  // device_byte, sector_count_reg, lba_low,
                                         // lba_mid, lba_high, lba_ext_low,
                                         // command_byte, chunk_sectors[64:56]
    output logic [1:0]  o_m_axis_tuser,  // addressing_mode
    output logic        o_m_axis_tlast   // last
);

    atatf_pkg::t_cfg    r_cfg;
    atatf_pkg::t_chunk  q_wr_data, q_rd_data;
    atatf_pkg::t_result result;
    logic               q_push, q_pop, q_full, q_empty;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lba_supported <= 1'b1;
            r_cfg.drive_number  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                atatf_pkg::REG_LBA_SUPPORTED: r_cfg.lba_supported <= i_cfg_wdata;
                atatf_pkg::REG_DRIVE_NUMBER:  r_cfg.drive_number  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    atatf_front #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_func         (i_s_axis_tuser),
        .i_start_lba    (i_s_axis_tdata[31:0]),
        .i_sector_count (i_s_axis_tdata[46:32]),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_data       (q_wr_data)
    );

    atatf_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rd_data)
    );

    atatf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_rd_data),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_result  (result)
    );

    // Output packing
    assign o_m_axis_tdata = {7'd0,
                             result.chunk_sectors,
                             result.command_byte,
                             result.lba_ext_low,
                             result.lba_high,
                             result.lba_mid,
                             result.lba_low,
                             result.sector_count_reg,
                             result.device_byte};
    assign o_m_axis_tuser = result.addressing_mode;
    assign o_m_axis_tlast = result.last;

endmodule
